/* rtl/core/tds_pkg.sv */
`timescale 1ns / 1ps
package tds_pkg;

    localparam int MAX_TRIANGLES = 64;
    localparam int MAX_VERTICES  = 256;
    localparam int DEPTH_BITS    = 16;

    localparam logic OP_WRITE    = 1'b0;
    localparam logic OP_TRIANGLE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_ADD,
        S_STORE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       in_ready;
        logic [1:0] rd_sel;
        logic       acc_clr;
        logic       acc_add;
        logic       tri_store;
        logic       scan_clr;
        logic       scan_rd;
        logic       out_valid;
    } t_cmd;

    typedef struct packed {
        logic in_xfer;
        logic in_op;
        logic is_final;
        logic scan_last;
        logic out_xfer;
        logic emit_last;
    } t_status;

    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

endpackage

/* rtl/core/tds_if.sv */
`timescale 1ns / 1ps
interface tds_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [7:0]         vertex_slot;
    logic signed [15:0] vertex_depth;
    logic [7:0]         corner_a;
    logic [7:0]         corner_b;
    logic [7:0]         corner_c;
    logic               final_triangle;

    modport source (output valid, op, vertex_slot, vertex_depth, corner_a, corner_b,
                    corner_c, final_triangle, input ready);
    modport sink (input valid, op, vertex_slot, vertex_depth, corner_a, corner_b,
                  corner_c, final_triangle, output ready);
endinterface

interface tds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_a;
    logic [7:0] out_b;
    logic [7:0] out_c;
    logic       end_of_batch;
    logic       dropped_any;

    modport source (output valid, out_a, out_b, out_c, end_of_batch, dropped_any,
                    input ready);
    modport sink (input valid, out_a, out_b, out_c, end_of_batch, dropped_any,
                  output ready);
endinterface

/* rtl/core/tds_ctrl.sv */
`timescale 1ns / 1ps
module tds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tds_pkg::t_status i_status,
    output tds_pkg::t_cmd    o_cmd
);

    tds_pkg::t_state r_state;
    tds_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tds_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tds_pkg::S_IDLE: begin
                if (i_status.in_xfer && i_status.in_op == tds_pkg::OP_TRIANGLE) begin
                    n_state = tds_pkg::S_RD_A;
                end
            end
            tds_pkg::S_RD_A:  n_state = tds_pkg::S_RD_B;
            tds_pkg::S_RD_B:  n_state = tds_pkg::S_RD_C;
            tds_pkg::S_RD_C:  n_state = tds_pkg::S_ADD;
            tds_pkg::S_ADD:   n_state = tds_pkg::S_STORE;
            tds_pkg::S_STORE: begin
                n_state = i_status.is_final ? tds_pkg::S_SCAN : tds_pkg::S_IDLE;
            end
            tds_pkg::S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = tds_pkg::S_DRAIN;
                end
            end
            tds_pkg::S_DRAIN: n_state = tds_pkg::S_EMIT;
            tds_pkg::S_EMIT: begin
                if (i_status.out_xfer) begin
                    n_state = i_status.emit_last ? tds_pkg::S_IDLE : tds_pkg::S_SCAN;
                end
            end
            default: n_state = tds_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            tds_pkg::S_IDLE: o_cmd.in_ready = 1'b1;
            tds_pkg::S_RD_A: begin
                o_cmd.rd_sel  = tds_pkg::SEL_A;
                o_cmd.acc_clr = 1'b1;
            end
            tds_pkg::S_RD_B: begin
                o_cmd.rd_sel  = tds_pkg::SEL_B;
                o_cmd.acc_add = 1'b1;
            end
            tds_pkg::S_RD_C: begin
                o_cmd.rd_sel  = tds_pkg::SEL_C;
                o_cmd.acc_add = 1'b1;
            end
            tds_pkg::S_ADD: o_cmd.acc_add = 1'b1;
            tds_pkg::S_STORE: begin
                o_cmd.tri_store = 1'b1;
                o_cmd.scan_clr  = 1'b1;
            end
            tds_pkg::S_SCAN: o_cmd.scan_rd = 1'b1;
            tds_pkg::S_EMIT: begin
                o_cmd.out_valid = 1'b1;
                o_cmd.scan_clr  = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* rtl/core/tds_dp.sv */
`timescale 1ns / 1ps
module tds_dp #(
    parameter int MAX_TRIANGLES = tds_pkg::MAX_TRIANGLES,
    parameter int MAX_VERTICES  = tds_pkg::MAX_VERTICES,
    parameter int DEPTH_BITS    = tds_pkg::DEPTH_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tds_pkg::t_cmd      i_cmd,
    input  logic               i_in_valid,
    input  logic               i_op,
    input  logic [7:0]         i_vertex_slot,
    input  logic signed [15:0] i_vertex_depth,
    input  logic [7:0]         i_corner_a,
    input  logic [7:0]         i_corner_b,
    input  logic [7:0]         i_corner_c,
    input  logic               i_final_triangle,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_a,
    output logic [7:0]         o_out_b,
    output logic [7:0]         o_out_c,
    output logic               o_end_of_batch,
    output logic               o_dropped_any,
    output tds_pkg::t_status   o_status
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int TW = $clog2(MAX_TRIANGLES);
    localparam int CW = $clog2(MAX_TRIANGLES + 1);
    localparam int SW = DEPTH_BITS + 2;

    logic signed [DEPTH_BITS-1:0] r_depth_mem [MAX_VERTICES];
    logic [23:0]                  r_tri_idx_mem [MAX_TRIANGLES];
    logic signed [SW-1:0]         r_tri_sum_mem [MAX_TRIANGLES];

    logic                  in_xfer;
    logic                  out_xfer;
    logic [31:0]           slot_ext;
    logic signed [31:0]    depth_ext;
    logic [7:0]            rd_corner;
    logic [31:0]           rd_ext;
    logic signed [SW-1:0]  rd_term;
    logic                  take;

    logic [7:0]                   r_ca, r_cb, r_cc;
    logic                         r_final;
    logic signed [DEPTH_BITS-1:0] r_rd_dat;
    logic                         r_rd_inr;
    logic signed [SW-1:0]         r_acc;
    logic [CW-1:0]                r_cnt;
    logic                         r_ovf;
    logic [CW-1:0]                r_scan_idx;
    logic                         r_cmp_vld;
    logic [TW-1:0]                r_cmp_idx;
    logic [23:0]                  r_ent_idx;
    logic signed [SW-1:0]         r_ent_sum;
    logic                         r_best_vld;
    logic [TW-1:0]                r_best_pos;
    logic [23:0]                  r_best_idx;
    logic signed [SW-1:0]         r_best_sum;
    logic [CW-1:0]                r_emit_cnt;
    logic [MAX_TRIANGLES-1:0]     r_done;

    assign in_xfer   = i_in_valid && i_cmd.in_ready;
    assign out_xfer  = i_cmd.out_valid && i_out_ready;
    assign slot_ext  = {24'd0, i_vertex_slot};
    assign depth_ext = 32'(i_vertex_depth);

    always_comb begin
        case (i_cmd.rd_sel)
            tds_pkg::SEL_A: rd_corner = r_ca;
            tds_pkg::SEL_B: rd_corner = r_cb;
            default:        rd_corner = r_cc;
        endcase
    end
    assign rd_ext  = {24'd0, rd_corner};
    assign rd_term = r_rd_inr ? SW'(r_rd_dat) : '0;

    // depth store and latched triangle corners
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_op == tds_pkg::OP_WRITE && slot_ext < 32'(MAX_VERTICES)) begin
            r_depth_mem[slot_ext[AW-1:0]] <= depth_ext[DEPTH_BITS-1:0];
        end
        if (in_xfer) begin
            r_ca    <= i_corner_a;
            r_cb    <= i_corner_b;
            r_cc    <= i_corner_c;
            r_final <= i_final_triangle;
        end
        r_rd_dat <= r_depth_mem[rd_ext[AW-1:0]];
        r_rd_inr <= rd_ext < 32'(MAX_VERTICES);
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + rd_term;
        end
    end

    // triangle store, scanned in full for each emitted entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.tri_store && r_cnt < CW'(MAX_TRIANGLES)) begin
            r_tri_idx_mem[r_cnt[TW-1:0]] <= {r_ca, r_cb, r_cc};
            r_tri_sum_mem[r_cnt[TW-1:0]] <= r_acc;
        end
        r_ent_idx <= r_tri_idx_mem[r_scan_idx[TW-1:0]];
        r_ent_sum <= r_tri_sum_mem[r_scan_idx[TW-1:0]];
        r_cmp_idx <= r_scan_idx[TW-1:0];
    end

    // strict compare keeps the earliest of equal sums
    assign take = r_cmp_vld && !r_done[r_cmp_idx] &&
                  (!r_best_vld || r_ent_sum > r_best_sum);

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_pos <= r_cmp_idx;
            r_best_idx <= r_ent_idx;
            r_best_sum <= r_ent_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
            r_best_vld <= 1'b0;
            r_emit_cnt <= '0;
            r_done     <= '0;
        end else begin
            if (i_cmd.tri_store) begin
                if (r_cnt < CW'(MAX_TRIANGLES)) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.scan_clr) begin
                r_scan_idx <= '0;
                r_cmp_vld  <= 1'b0;
            end else if (i_cmd.scan_rd) begin
                r_scan_idx <= r_scan_idx + 1'b1;
                r_cmp_vld  <= 1'b1;
            end else begin
                r_cmp_vld  <= 1'b0;
            end
            if (i_cmd.scan_rd && r_scan_idx == '0) begin
                r_best_vld <= 1'b0;
            end else if (take) begin
                r_best_vld <= 1'b1;
            end
            if (out_xfer) begin
                if (o_end_of_batch) begin
                    r_cnt      <= '0;
                    r_ovf      <= 1'b0;
                    r_emit_cnt <= '0;
                    r_done     <= '0;
                end else begin
                    r_emit_cnt         <= r_emit_cnt + 1'b1;
                    r_done[r_best_pos] <= 1'b1;
                end
            end
        end
    end

    assign o_out_a        = r_best_idx[23:16];
    assign o_out_b        = r_best_idx[15:8];
    assign o_out_c        = r_best_idx[7:0];
    assign o_end_of_batch = r_emit_cnt == r_cnt - 1'b1;
    assign o_dropped_any  = r_ovf;

    assign o_status.in_xfer   = in_xfer;
    assign o_status.in_op     = i_op;
    assign o_status.is_final  = r_final;
    assign o_status.scan_last = r_scan_idx == r_cnt - 1'b1;
    assign o_status.out_xfer  = out_xfer;
    assign o_status.emit_last = o_end_of_batch;

endmodule

/* rtl/core/triangle_depth_sort_unit.sv */
`timescale 1ns / 1ps
// channel  dir  role    transfer carries
// i_in     in   sink    op, vertex_slot, vertex_depth, corner_a/b/c, final_triangle
// o_out    out  source  out_a/b/c, end_of_batch, dropped_any
//
// a depth write is taken while idle; a triangle reads the depth memory once for each
// of its three corners, adds the depths and then stores the triangle
// after the final triangle each emitted triple takes a full scan of the n triangles
// in the batch, one triangle memory read per cycle, plus any output stall
// reset (synchronous, active low) clears counts, flags and the controller
module triangle_depth_sort_unit #(
    parameter int MAX_TRIANGLES = tds_pkg::MAX_TRIANGLES,
    parameter int MAX_VERTICES  = tds_pkg::MAX_VERTICES,
    parameter int DEPTH_BITS    = tds_pkg::DEPTH_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tds_in_if.sink    i_in,
    tds_out_if.source o_out
);

    tds_pkg::t_cmd    cmd;
    tds_pkg::t_status status;

    tds_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tds_dp #(
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .MAX_VERTICES  (MAX_VERTICES),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_in_valid       (i_in.valid),
        .i_op             (i_in.op),
        .i_vertex_slot    (i_in.vertex_slot),
        .i_vertex_depth   (i_in.vertex_depth),
        .i_corner_a       (i_in.corner_a),
        .i_corner_b       (i_in.corner_b),
        .i_corner_c       (i_in.corner_c),
        .i_final_triangle (i_in.final_triangle),
        .i_out_ready      (o_out.ready),
        .o_out_a          (o_out.out_a),
        .o_out_b          (o_out.out_b),
        .o_out_c          (o_out.out_c),
        .o_end_of_batch   (o_out.end_of_batch),
        .o_dropped_any    (o_out.dropped_any),
        .o_status         (status)
    );

    assign i_in.ready  = cmd.in_ready;
    assign o_out.valid = cmd.out_valid;

    a_busy_after_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.op == tds_pkg::OP_TRIANGLE |=> !i_in.ready)
        else $error("input taken during triangle processing");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while emitting");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.end_of_batch |=> i_in.ready && !o_out.valid)
        else $error("not idle after last triple");

endmodule
